// ===== design/lrb_pkg.sv =====
// Shared types and constants for the log ring buffer.
`timescale 1ns / 1ps
`default_nettype none
package lrb_pkg;

    localparam int CMD_W  = 2;
    localparam int DATA_W = 8;
    localparam int IDX_W  = 10;
    localparam int STAT_W = 2;

    // Item command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 2'd0,
        CMD_DONE = 2'd1,
        CMD_KICK = 2'd2,
        CMD_READ = 2'd3
    } t_cmd;

    // Message status codes
    localparam logic [STAT_W-1:0] STAT_NONE   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_COMMIT = 2'd1;
    localparam logic [STAT_W-1:0] STAT_DROP   = 2'd2;

    // Controller to datapath: one strobe per command, high on the accepting edge
    typedef struct packed {
        logic push;
        logic done;
        logic kick;
        logic rd;
    } t_dp_cmd;

endpackage
`default_nettype wire

// ===== design/lrb_if.sv =====
// Valid/ready channel interfaces for the input items and the result items.
`timescale 1ns / 1ps
`default_nettype none
interface lrb_in_if;
    import lrb_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] data;
    logic              last_of_message;
    logic [IDX_W-1:0]  read_index;

    modport source (output valid, cmd, data, last_of_message, read_index, input ready);
    modport sink   (input valid, cmd, data, last_of_message, read_index, output ready);
endinterface

interface lrb_out_if;
    import lrb_pkg::*;

    logic              valid;
    logic              ready;
    logic              burst_valid;
    logic [IDX_W-1:0]  burst_start;
    logic [IDX_W-1:0]  burst_length;
    logic [DATA_W-1:0] read_data;
    logic [STAT_W-1:0] message_status;

    modport source (output valid, burst_valid, burst_start, burst_length, read_data,
                    message_status, input ready);
    modport sink   (input valid, burst_valid, burst_start, burst_length, read_data,
                    message_status, output ready);
endinterface
`default_nettype wire

// ===== design/lrb_ctrl.sv =====
// Handshake controller: output register occupancy and command decode.
`timescale 1ns / 1ps
`default_nettype none
module lrb_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [lrb_pkg::CMD_W-1:0] i_cmd,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output lrb_pkg::t_dp_cmd           o_dp_cmd
);
    import lrb_pkg::*;

    typedef enum logic {
        S_EMPTY,
        S_FULL
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    // Take a new item when the result slot is empty or drains this cycle
    assign o_in_ready  = (r_state == S_EMPTY) || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = (r_state == S_FULL);

    always_comb begin
        o_dp_cmd = '0;
        if (accept) begin
            case (t_cmd'(i_cmd))
                CMD_PUSH: o_dp_cmd.push = 1'b1;
                CMD_DONE: o_dp_cmd.done = 1'b1;
                CMD_KICK: o_dp_cmd.kick = 1'b1;
                CMD_READ: o_dp_cmd.rd   = 1'b1;
                default:  o_dp_cmd      = '0;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_EMPTY: begin
                if (accept) n_state = S_FULL;
            end
            S_FULL: begin
                if (!accept && i_out_ready) n_state = S_EMPTY;
            end
            default: n_state = S_EMPTY;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_EMPTY;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// ===== design/lrb_datapath.sv =====
// Ring pointers, message staging, burst issue, byte store and result register.
`timescale 1ns / 1ps
`default_nettype none
module lrb_datapath #(
    parameter int BUF_DEPTH   = 1024,
    parameter int MSG_MAX_LEN = 127
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire lrb_pkg::t_dp_cmd           i_dp_cmd,
    input  wire logic [lrb_pkg::DATA_W-1:0] i_data,
    input  wire logic                       i_last,
    input  wire logic [lrb_pkg::IDX_W-1:0]  i_read_index,
    output logic                            o_burst_valid,
    output logic [lrb_pkg::IDX_W-1:0]       o_burst_start,
    output logic [lrb_pkg::IDX_W-1:0]       o_burst_length,
    output logic [lrb_pkg::DATA_W-1:0]      o_read_data,
    output logic [lrb_pkg::STAT_W-1:0]      o_message_status
);
    import lrb_pkg::*;

    localparam int AW    = $clog2(BUF_DEPTH);
    localparam int CNT_W = $clog2(MSG_MAX_LEN + 1);
    localparam int CMP_W = (AW > CNT_W) ? AW : CNT_W;

    // Pointer and message state
    logic [AW-1:0]    r_wp, n_wp;
    logic [AW-1:0]    r_rp, n_rp;
    logic             r_busy, n_busy;
    logic [AW-1:0]    r_issued, n_issued;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_ovf, n_ovf;

    // Result register
    logic              r_bv, n_bv;
    logic [IDX_W-1:0]  r_bs, n_bs;
    logic [IDX_W-1:0]  r_bl, n_bl;
    logic [STAT_W-1:0] r_stat, n_stat;
    logic              r_rd_sel;

    // Byte store
    logic [DATA_W-1:0] r_store [BUF_DEPTH];
    logic [DATA_W-1:0] r_mem_q;

    logic              we;
    logic [AW-1:0]     waddr;
    logic [AW-1:0]     raddr;
    logic [AW-1:0]     used;
    logic [AW-1:0]     space;
    logic [AW-1:0]     len;
    logic              try_issue;
    logic              any_cmd;

    assign waddr   = r_wp + AW'(r_cnt);
    assign raddr   = AW'(i_read_index);
    assign used    = r_wp - r_rp;
    assign space   = AW'(BUF_DEPTH - 1) - used;
    assign any_cmd = i_dp_cmd.push || i_dp_cmd.done || i_dp_cmd.kick || i_dp_cmd.rd;

    always_comb begin
        n_wp      = r_wp;
        n_rp      = r_rp;
        n_busy    = r_busy;
        n_issued  = r_issued;
        n_cnt     = r_cnt;
        n_ovf     = r_ovf;
        n_bv      = 1'b0;
        n_bs      = '0;
        n_bl      = '0;
        n_stat    = STAT_NONE;
        we        = 1'b0;
        try_issue = 1'b0;
        len       = '0;

        if (i_dp_cmd.push) begin
            // Bytes past the length limit are ignored; a full ring drops the message
            if (!r_ovf && (r_cnt < CNT_W'(MSG_MAX_LEN))) begin
                if (CMP_W'(r_cnt) < CMP_W'(space)) begin
                    we    = 1'b1;
                    n_cnt = r_cnt + 1'b1;
                end else begin
                    n_ovf = 1'b1;
                end
            end
            if (i_last) begin
                if (n_ovf) begin
                    n_stat = STAT_DROP;
                end else begin
                    n_wp      = r_wp + AW'(n_cnt);
                    n_stat    = STAT_COMMIT;
                    try_issue = 1'b1;
                end
                n_cnt = '0;
                n_ovf = 1'b0;
            end
        end

        if (i_dp_cmd.done) begin
            // Retire the burst in flight, if any
            if (r_busy) begin
                n_rp   = r_rp + r_issued;
                n_busy = 1'b0;
            end
            try_issue = 1'b1;
        end

        if (i_dp_cmd.kick) begin
            try_issue = 1'b1;
        end

        if (try_issue && !n_busy && (n_wp != n_rp)) begin
            // Contiguous run: up to the head, or up to the end of the store on wrap
            len      = (n_wp > n_rp) ? (n_wp - n_rp) : (AW'(0) - n_rp);
            n_busy   = 1'b1;
            n_issued = len;
            n_bv     = 1'b1;
            n_bs     = IDX_W'(n_rp);
            n_bl     = IDX_W'(len);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_rp     <= '0;
            r_busy   <= 1'b0;
            r_issued <= '0;
            r_cnt    <= '0;
            r_ovf    <= 1'b0;
        end else begin
            r_wp     <= n_wp;
            r_rp     <= n_rp;
            r_busy   <= n_busy;
            r_issued <= n_issued;
            r_cnt    <= n_cnt;
            r_ovf    <= n_ovf;
        end
    end

    // Result payload: load on every accepted item
    always_ff @(posedge i_clk) begin
        if (any_cmd) begin
            r_bv     <= n_bv;
            r_bs     <= n_bs;
            r_bl     <= n_bl;
            r_stat   <= n_stat;
            r_rd_sel <= i_dp_cmd.rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_store[waddr] <= i_data;
        end
        if (i_dp_cmd.rd) begin
            r_mem_q <= r_store[raddr];
        end
    end

    assign o_burst_valid    = r_bv;
    assign o_burst_start    = r_bs;
    assign o_burst_length   = r_bl;
    assign o_read_data      = r_rd_sel ? r_mem_q : '0;
    assign o_message_status = r_stat;

endmodule
`default_nettype wire

// ===== design/log_ring_buffer_with_burst_issue.sv =====
// Top level of the log ring buffer with burst transfer issue.
`timescale 1ns / 1ps
`default_nettype none
// Log ring buffer. Each input transfer carries one command: push a message
// byte, report a finished transfer, kick the burst issuer, or read a store
// byte. Every item yields exactly one result transfer, registered, in the cycle
// after the item is taken. Messages are staged just past the write pointer and
// become visible only on their last byte; a message longer than MSG_MAX_LEN
// is cut to that length, and one that does not fit in the free space
// (BUF_DEPTH - 1 less the bytes in use) is dropped whole and reported with a
// drop status. When no transfer is in flight and data waits, a commit, done
// or kick issues one contiguous burst (tail to head, or tail to the end of
// the store when the data wraps); done first retires the burst in flight.
// Rate: one item per clock while the output is taken. The input is ready while
// the result register is empty or its result is being taken in the same cycle,
// so a stalled output holds the input after one item. Store reads use the
// registered read port of the single byte memory, so read data is registered
// with the other result fields. The store is not cleared by reset: a read of a
// byte that was never written returns whatever the store holds. BUF_DEPTH must
// be a power of two; indexes and lengths on the ports are 10 bits wide.
module log_ring_buffer_with_burst_issue #(
    parameter int BUF_DEPTH   = 1024,
    parameter int MSG_MAX_LEN = 127
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lrb_in_if.sink     i_in,
    lrb_out_if.source  o_out
);
    import lrb_pkg::*;

    t_dp_cmd dp_cmd;

    // Handshake and command decode
    lrb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_cmd       (i_in.cmd),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_dp_cmd    (dp_cmd)
    );

    // Pointers, store and result register
    lrb_datapath #(
        .BUF_DEPTH   (BUF_DEPTH),
        .MSG_MAX_LEN (MSG_MAX_LEN)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_dp_cmd         (dp_cmd),
        .i_data           (i_in.data),
        .i_last           (i_in.last_of_message),
        .i_read_index     (i_in.read_index),
        .o_burst_valid    (o_out.burst_valid),
        .o_burst_start    (o_out.burst_start),
        .o_burst_length   (o_out.burst_length),
        .o_read_data      (o_out.read_data),
        .o_message_status (o_out.message_status)
    );

endmodule
`default_nettype wire
